@@ src/bdht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bdht_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_FETCH  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_BRENT      = 1'b1;

  localparam int         SIZE_W       = 11;
  localparam logic [10:0] SIZE_RESET  = 11'd1024;
  localparam int         SIZE_MIN     = 3;

endpackage
`default_nettype wire

@@ src/bdht_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface bdht_in_if #(parameter int KEY_WIDTH = 32);
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [KEY_WIDTH-1:0] key;
  logic [9:0]           slot_index;
  modport source (output valid, action, key, slot_index, input ready);
  modport sink (input valid, action, key, slot_index, output ready);
endinterface

interface bdht_out_if #(parameter int KEY_WIDTH = 32);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [KEY_WIDTH-1:0] entry_key;
  logic                 entry_passbit;
  logic [10:0]          entry_count;
  logic [31:0]          probe_total;
  logic [10:0]          passbit_count;
  modport source (output valid, status, entry_key, entry_passbit, entry_count,
                  probe_total, passbit_count, input ready);
  modport sink (input valid, status, entry_key, entry_passbit, entry_count,
                probe_total, passbit_count, output ready);
endinterface
`default_nettype wire

@@ src/bdht_mod.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bdht_mod #(
  parameter int NW = 32,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [DW-1:0]      rem
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] sh_r;
  logic [DW-1:0] rem_r, den_r, rem_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   t;

  always_comb begin
    t = {rem_r, sh_r[NW-1]};
    if (t >= {1'b0, den_r}) rem_nxt = DW'(t - {1'b0, den_r});
    else rem_nxt = t[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        sh_r   <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        sh_r  <= {sh_r[NW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

@@ src/brent_double_hash_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake    word
// in_if    in   valid/ready  action, key, slot_index
// out_if   out  valid/ready  status, entry_key, entry_passbit, counters
// apb      in   psel/penable table_size (0x0), brent_enable (0x4)
// one operation at a time; each probe is a read and a check of the single-port table ram,
// and a key's home slot and step are each found by a modulo in the shared divider
// insert: hash, then probes; brent adds a step modulo per candidate, probes or pass marks,
// and the move; fetch: hash, then probes
// read entry: one table read; clear: a pass over every table entry
// after reset a clearing pass over every table entry runs before the first word is taken
// a result waits in the output register; the next word is taken once it is delivered or queued
module brent_double_hash_table_unit
  import bdht_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bdht_in_if.sink          in_if,
  bdht_out_if.source       out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int SW  = $clog2(TABLE_DEPTH + 1);
  localparam int SW1 = SW + 1;

  typedef struct packed {
    logic                 occ;
    logic                 pass;
    logic [KEY_WIDTH-1:0] key;
  } ent_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DIV_H, S_DIV_S, S_W1_RD, S_W1_CK, S_B_RD, S_B_CK, S_B_DIV,
    S_B2_RD, S_B2_CK, S_C1_RD, S_C1_CK, S_C2_RD, S_C2_CK, S_FIX, S_F_RD, S_F_CK,
    S_E_RD, S_E_CK, S_DONE
  } state_t;

  logic [SIZE_W-1:0] ts_r;
  logic              brent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r    <= SIZE_RESET;
      brent_r <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TABLE_SIZE: ts_r    <= pwdata[SIZE_W-1:0];
        REG_BRENT:      brent_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TABLE_SIZE: prdata = 32'(ts_r);
      REG_BRENT:      prdata = 32'(brent_r);
      default:        prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  logic [SW-1:0] eff;
  always_comb begin
    if (32'(ts_r) < SIZE_MIN) eff = SW'(SIZE_MIN);
    else if (32'(ts_r) > TABLE_DEPTH) eff = SW'(TABLE_DEPTH);
    else eff = SW'(ts_r);
  end

  ent_t mem [TABLE_DEPTH];
  ent_t rd_r, mem_wd;
  logic [AW-1:0] mem_addr;
  logic mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_r <= mem[mem_addr];
  end

  logic                 div_go_r, div_done;
  logic [KEY_WIDTH-1:0] div_num_r;
  logic [SW-1:0]        div_den_r, div_rem;

  bdht_mod #(.NW(KEY_WIDTH), .DW(SW)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .rem   (div_rem)
  );

  state_t               state_r;
  act_t                 act_r;
  logic [KEY_WIDTH-1:0] key_r, cand_key_r, best_key_r, wkey_r;
  logic [9:0]           idx_r;
  logic [SW-1:0]        s_r, st_r, st2_r, best_st_r, wstep_r;
  logic [AW-1:0]        home_r, p_r, q_r, r_r, best_slot_r, clr_r;
  logic [SW-1:0]        m_r, n_r, i_r, cost_r, plain_r, best_r;
  logic                 bmode_r, clr_cmd_r;
  logic [SW-1:0]        cnt_r, pcnt_r;
  logic [31:0]          psum_r;
  logic [32:0]          psum_add;
  logic [1:0]           res_st_r;
  logic [KEY_WIDTH-1:0] res_key_r;
  logic                 res_pass_r;
  logic                 out_valid_r;
  logic [1:0]           out_st_r;
  logic [KEY_WIDTH-1:0] out_key_r;
  logic                 out_pass_r;
  logic [10:0]          out_cnt_r, out_pcnt_r;
  logic [31:0]          out_psum_r;

  function automatic logic [AW-1:0] bck(input logic [AW-1:0] p, input logic [SW-1:0] st,
                                        input logic [SW-1:0] s);
    logic [SW:0] pe, t;
    pe = SW1'(p);
    if (pe >= {1'b0, st}) t = pe - {1'b0, st};
    else t = pe + {1'b0, s} - {1'b0, st};
    return t[AW-1:0];
  endfunction

  assign in_if.ready = (state_r == S_IDLE);
  assign psum_add = {1'b0, psum_r} + 33'(best_r);

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = p_r;
    mem_wd   = rd_r;
    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        mem_wd   = '0;
      end
      S_B_RD, S_C1_RD: mem_addr = q_r;
      S_B2_RD:         mem_addr = r_r;
      S_C1_CK: begin
        mem_addr    = q_r;
        mem_we      = !rd_r.pass;
        mem_wd.pass = 1'b1;
      end
      S_C2_CK: begin
        mem_we = 1'b1;
        if (rd_r.occ) mem_wd.pass = 1'b1;
        else begin
          mem_wd.occ = 1'b1;
          mem_wd.key = wkey_r;
        end
      end
      S_FIX: begin
        mem_we   = 1'b1;
        mem_addr = best_slot_r;
        mem_wd   = '{occ: 1'b1, pass: 1'b1, key: key_r};
      end
      S_E_RD: mem_addr = AW'(idx_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      clr_cmd_r   <= 1'b0;
      cnt_r       <= '0;
      pcnt_r      <= '0;
      psum_r      <= '0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (out_valid_r && out_if.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(TABLE_DEPTH - 1)) begin
            state_r <= clr_cmd_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_if.valid) begin
            act_r      <= act_t'(in_if.action);
            key_r      <= in_if.key;
            idx_r      <= in_if.slot_index;
            s_r        <= eff;
            res_key_r  <= '0;
            res_pass_r <= 1'b0;
            res_st_r   <= ST_OK;
            div_num_r  <= in_if.key;
            div_den_r  <= eff;
            case (act_t'(in_if.action))
              ACT_INSERT: begin
                if (cnt_r >= eff) begin
                  res_st_r <= ST_FULL;
                  state_r  <= S_DONE;
                end else begin
                  div_go_r <= 1'b1;
                  state_r  <= S_DIV_H;
                end
              end
              ACT_FETCH: begin
                div_go_r <= 1'b1;
                state_r  <= S_DIV_H;
              end
              ACT_READ: begin
                if (32'(in_if.slot_index) < 32'(eff)) state_r <= S_E_RD;
                else begin
                  res_st_r <= ST_MISS;
                  state_r  <= S_DONE;
                end
              end
              default: begin
                cnt_r     <= '0;
                pcnt_r    <= '0;
                psum_r    <= '0;
                clr_r     <= '0;
                clr_cmd_r <= 1'b1;
                state_r   <= S_CLEAR;
              end
            endcase
          end
        end
        S_DIV_H: begin
          if (div_done) begin
            home_r    <= AW'(div_rem);
            div_den_r <= s_r - SW'(2);
            div_go_r  <= 1'b1;
            state_r   <= S_DIV_S;
          end
        end
        S_DIV_S: begin
          if (div_done) begin
            st_r    <= div_rem + 1'b1;
            p_r     <= home_r;
            m_r     <= '0;
            n_r     <= '0;
            state_r <= (act_r == ACT_FETCH) ? S_F_RD : S_W1_RD;
          end
        end
        S_W1_RD: state_r <= S_W1_CK;
        S_W1_CK: begin
          if (!rd_r.occ) begin
            plain_r <= m_r + 1'b1;
            best_r  <= m_r + 1'b1;
            if (brent_r && m_r != '0) begin
              i_r     <= '0;
              q_r     <= home_r;
              state_r <= S_B_RD;
            end else begin
              p_r     <= home_r;
              wstep_r <= st_r;
              wkey_r  <= key_r;
              bmode_r <= 1'b0;
              state_r <= S_C2_RD;
            end
          end else if (rd_r.key == key_r) begin
            res_st_r <= ST_DUP;
            state_r  <= S_DONE;
          end else if (n_r + 1'b1 == s_r) begin
            res_st_r <= ST_FULL;
            state_r  <= S_DONE;
          end else begin
            m_r     <= m_r + 1'b1;
            n_r     <= n_r + 1'b1;
            p_r     <= bck(p_r, st_r, s_r);
            state_r <= S_W1_RD;
          end
        end
        S_B_RD: state_r <= S_B_CK;
        S_B_CK: begin
          cand_key_r <= rd_r.key;
          div_num_r  <= rd_r.key;
          div_den_r  <= s_r - SW'(2);
          div_go_r   <= 1'b1;
          state_r    <= S_B_DIV;
        end
        S_B_DIV: begin
          if (div_done) begin
            st2_r   <= div_rem + 1'b1;
            r_r     <= q_r;
            cost_r  <= i_r + 1'b1;
            state_r <= S_B2_RD;
          end
        end
        S_B2_RD: state_r <= S_B2_CK;
        S_B2_CK: begin
          if (!rd_r.occ || (cost_r + 1'b1 >= best_r)) begin
            if (!rd_r.occ) begin
              best_r      <= cost_r;
              best_slot_r <= q_r;
              best_key_r  <= cand_key_r;
              best_st_r   <= st2_r;
            end
            if (i_r + 1'b1 == m_r) begin
              q_r     <= home_r;
              state_r <= S_C1_RD;
            end else begin
              i_r     <= i_r + 1'b1;
              q_r     <= bck(q_r, st_r, s_r);
              state_r <= S_B_RD;
            end
          end else begin
            cost_r  <= cost_r + 1'b1;
            r_r     <= bck(r_r, st2_r, s_r);
            state_r <= S_B2_RD;
          end
        end
        S_C1_RD: begin
          if (best_r >= plain_r) begin
            p_r     <= home_r;
            wstep_r <= st_r;
            wkey_r  <= key_r;
            bmode_r <= 1'b0;
            state_r <= S_C2_RD;
          end else if (q_r == best_slot_r) begin
            p_r     <= best_slot_r;
            wstep_r <= best_st_r;
            wkey_r  <= best_key_r;
            bmode_r <= 1'b1;
            state_r <= S_C2_RD;
          end else state_r <= S_C1_CK;
        end
        S_C1_CK: begin
          if (!rd_r.pass) pcnt_r <= pcnt_r + 1'b1;
          q_r     <= bck(q_r, st_r, s_r);
          state_r <= S_C1_RD;
        end
        S_C2_RD: state_r <= S_C2_CK;
        S_C2_CK: begin
          if (rd_r.occ) begin
            if (!rd_r.pass) pcnt_r <= pcnt_r + 1'b1;
            p_r     <= bck(p_r, wstep_r, s_r);
            state_r <= S_C2_RD;
          end else if (bmode_r) state_r <= S_FIX;
          else begin
            cnt_r   <= cnt_r + 1'b1;
            psum_r  <= psum_add[32] ? 32'hFFFF_FFFF : psum_add[31:0];
            state_r <= S_DONE;
          end
        end
        S_FIX: begin
          cnt_r   <= cnt_r + 1'b1;
          psum_r  <= psum_add[32] ? 32'hFFFF_FFFF : psum_add[31:0];
          state_r <= S_DONE;
        end
        S_F_RD: state_r <= S_F_CK;
        S_F_CK: begin
          if (n_r == '0 && !rd_r.occ) begin
            res_st_r <= ST_MISS;
            state_r  <= S_DONE;
          end else if (rd_r.occ && rd_r.key == key_r) begin
            res_key_r <= key_r;
            state_r   <= S_DONE;
          end else if (!rd_r.pass || (n_r + 1'b1 == s_r)) begin
            res_st_r <= ST_MISS;
            state_r  <= S_DONE;
          end else begin
            n_r     <= n_r + 1'b1;
            p_r     <= bck(p_r, st_r, s_r);
            state_r <= S_F_RD;
          end
        end
        S_E_RD: state_r <= S_E_CK;
        S_E_CK: begin
          if (rd_r.occ) begin
            res_key_r  <= rd_r.key;
            res_pass_r <= rd_r.pass;
          end else res_st_r <= ST_MISS;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_st_r    <= res_st_r;
            out_key_r   <= res_key_r;
            out_pass_r  <= res_pass_r;
            out_cnt_r   <= 11'(cnt_r);
            out_pcnt_r  <= 11'(pcnt_r);
            out_psum_r  <= psum_r;
            clr_cmd_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_st_r;
  assign out_if.entry_key     = out_key_r;
  assign out_if.entry_passbit = out_pass_r;
  assign out_if.entry_count   = out_cnt_r;
  assign out_if.probe_total   = out_psum_r;
  assign out_if.passbit_count = out_pcnt_r;

`ifndef ASSERT_OFF
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_if.ready)
    else $error("word taken during clearing pass");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("second word taken while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= s_r) || (cnt_r == '0) || $past(cnt_r >= s_r))
    else $error("stored count above table size");
`endif

endmodule
`default_nettype wire

@@ tb/brent_double_hash_table_unit_tb.sv @@
`timescale 1ns / 1ps
module brent_double_hash_table_unit_tb;
  import bdht_pkg::*;

  localparam int DEPTH = 1024;
  localparam int LIMIT = 400000;

  typedef struct packed {
    status_t     status;
    logic [31:0] entry_key;
    logic        entry_passbit;
    logic [10:0] entry_count;
    logic [31:0] probe_total;
    logic [10:0] passbit_count;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bdht_in_if  in_if ();
  bdht_out_if out_if ();

  brent_double_hash_table_unit dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // model of the table
  logic [31:0] keys [DEPTH];
  bit          used [DEPTH];
  bit          passed [DEPTH];
  int unsigned n_keys, probes, n_pass;
  int unsigned size_reg, brent_reg;

  answer_t answers [$];
  int unsigned errors, sent, got, idle_cycles, hold_cycles;
  int unsigned n_ins_ok, n_dup, n_full, n_found, n_moves;
  bit long_hold;

  function automatic int unsigned eff_size();
    if (size_reg < 3) return 3;
    if (size_reg > DEPTH) return DEPTH;
    return size_reg;
  endfunction

  function automatic int unsigned step_of(logic [31:0] k, int unsigned s);
    return (k % (s - 2)) + 1;
  endfunction

  function automatic int unsigned back(int unsigned p, int unsigned st, int unsigned s);
    return (p >= st) ? p - st : p + s - st;
  endfunction

  function automatic void set_pass(int unsigned p);
    if (!passed[p]) begin
      passed[p] = 1;
      n_pass++;
    end
  endfunction

  function automatic void add_cost(int unsigned c);
    longint unsigned t;
    t = longint'(probes) + c;
    probes = 32'((t > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : t);
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < DEPTH; i++) begin
      used[i] = 0;
      passed[i] = 0;
      keys[i] = '0;
    end
    n_keys = 0;
    probes = 0;
    n_pass = 0;
  endfunction

  function automatic status_t insert_key(logic [31:0] k);
    int unsigned s, st, home, p, m, plain, best, best_slot, q, st2, r, c;
    bit free, ok;
    s = eff_size();
    if (n_keys >= s) return ST_FULL;
    st = step_of(k, s);
    home = k % s;
    p = home;
    m = 0;
    free = 0;
    for (int n = 0; n < s; n++) begin
      if (!used[p]) begin
        free = 1;
        break;
      end
      if (keys[p] == k) return ST_DUP;
      m++;
      p = back(p, st, s);
    end
    if (!free) return ST_FULL;
    plain = m + 1;
    best = plain;
    best_slot = 0;
    if (brent_reg[0]) begin
      q = home;
      for (int i = 0; i < m; i++) begin
        st2 = step_of(keys[q], s);
        r = q;
        c = 1 + i;
        ok = 0;
        for (int j = 0; j < s; j++) begin
          if (!used[r]) begin
            ok = 1;
            break;
          end
          r = back(r, st2, s);
          c++;
        end
        if (ok && c < best) begin
          best = c;
          best_slot = q;
        end
        q = back(q, st, s);
      end
    end
    if (best < plain) begin
      n_moves++;
      q = home;
      while (q != best_slot) begin
        set_pass(q);
        q = back(q, st, s);
      end
      st2 = step_of(keys[best_slot], s);
      r = best_slot;
      while (used[r]) begin
        set_pass(r);
        r = back(r, st2, s);
      end
      keys[r] = keys[best_slot];
      used[r] = 1;
      keys[best_slot] = k;
      add_cost(best);
    end else begin
      p = home;
      while (used[p]) begin
        set_pass(p);
        p = back(p, st, s);
      end
      keys[p] = k;
      used[p] = 1;
      add_cost(plain);
    end
    n_keys++;
    return ST_OK;
  endfunction

  function automatic bit fetch_key(logic [31:0] k);
    int unsigned s, st, p;
    s = eff_size();
    st = step_of(k, s);
    p = k % s;
    if (!used[p]) return 0;
    for (int n = 0; n < s; n++) begin
      if (used[p] && keys[p] == k) return 1;
      if (!passed[p]) return 0;
      p = back(p, st, s);
    end
    return 0;
  endfunction

  function automatic answer_t table_answer(act_t a, logic [31:0] k, logic [9:0] idx);
    answer_t r;
    r = '0;
    r.status = ST_OK;
    case (a)
      ACT_INSERT: begin
        r.status = insert_key(k);
        case (r.status)
          ST_OK: n_ins_ok++;
          ST_DUP: n_dup++;
          default: n_full++;
        endcase
      end
      ACT_FETCH: begin
        if (fetch_key(k)) begin
          r.entry_key = k;
          n_found++;
        end else begin
          r.status = ST_MISS;
        end
      end
      ACT_READ: begin
        if (idx < eff_size() && used[idx]) begin
          r.entry_key = keys[idx];
          r.entry_passbit = passed[idx];
        end else begin
          r.status = ST_MISS;
        end
      end
      default: wipe_table();
    endcase
    r.entry_count = 11'(n_keys);
    r.probe_total = probes;
    r.passbit_count = 11'(n_pass);
    return r;
  endfunction

  task automatic send_word(act_t a, logic [31:0] k, logic [9:0] idx);
    int unsigned gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) in_if.valid <= 1'b0;
    repeat (gap) @(posedge clk);
    in_if.valid <= 1'b1;
    in_if.action <= a;
    in_if.key <= k;
    in_if.slot_index <= idx;
    do @(posedge clk); while (!in_if.ready);
    answers.push_back(table_answer(a, k, idx));
    sent++;
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    repeat (DEPTH + 200) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    wait_drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'(4 * REG_TABLE_SIZE)) size_reg = 32'(val[10:0]);
    else brent_reg = 32'(val[0]);
  endtask

  task automatic set_mode(int unsigned s, bit b);
    write_reg(3'(4 * REG_TABLE_SIZE), s);
    write_reg(3'(4 * REG_BRENT), 32'(b));
  endtask

  function automatic logic [31:0] key_near(int unsigned s);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3 * s);
      default: return $urandom_range(0, 3 * s);
    endcase
  endfunction

  task automatic test_directed();
    set_mode(7, 1);
    send_word(ACT_READ, 0, 10'd0);
    send_word(ACT_FETCH, 32'd5, '0);
    send_word(ACT_INSERT, 32'hFFFF_FFFF, '0);
    send_word(ACT_INSERT, 32'd0, '0);
    send_word(ACT_INSERT, 32'hFFFF_FFFF, '0);
    for (int i = 1; i <= 7; i++) send_word(ACT_INSERT, 32'(7 * i), '0);
    send_word(ACT_INSERT, 32'd3, '0);
    send_word(ACT_FETCH, 32'hFFFF_FFFF, '0);
    send_word(ACT_FETCH, 32'd14, '0);
    send_word(ACT_FETCH, 32'd99, '0);
    for (int i = 0; i < 8; i++) send_word(ACT_READ, 0, 10'(i));
    send_word(ACT_READ, 0, 10'h3FF);
    send_word(ACT_CLEAR, '1, '1);
  endtask

  task automatic test_sizes();
    set_mode(0, 1);
    for (int i = 0; i < 5; i++) send_word(ACT_INSERT, key_near(3), '0);
    send_word(ACT_READ, 0, 10'd3);
    send_word(ACT_CLEAR, 0, '0);
    set_mode(2047, 0);
    for (int i = 0; i < 40; i++) send_word(ACT_INSERT, $urandom, '0);
    send_word(ACT_READ, 0, 10'd1023);
    send_word(ACT_CLEAR, 0, '0);
  endtask

  task automatic test_random(int unsigned count, int unsigned s, bit b);
    logic [31:0] k;
    int unsigned pick;
    set_mode(s, b);
    send_word(ACT_CLEAR, 0, '0);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      k = key_near(eff_size());
      if (pick < 55) send_word(ACT_INSERT, k, 10'($urandom));
      else if (pick < 85) send_word(ACT_FETCH, k, 10'($urandom));
      else if (pick < 98) send_word(ACT_READ, k, 10'($urandom_range(0, eff_size() + 2)));
      else send_word(ACT_CLEAR, k, 10'($urandom));
    end
  endtask

  task automatic test_backpressure();
    set_mode(13, 1);
    long_hold = 1'b1;
    for (int i = 0; i < 12; i++) send_word(ACT_INSERT, key_near(13), '0);
    long_hold = 1'b0;
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_cycles <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got++;
        if (answers.size() == 0) begin
          $error("unexpected word: status %0d", out_if.status);
          errors++;
        end else begin
          answer_t e;
          e = answers.pop_front();
          if (out_if.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_if.status); errors++;
          end
          if (out_if.entry_key !== e.entry_key) begin
            $error("entry_key exp %h got %h", e.entry_key, out_if.entry_key); errors++;
          end
          if (out_if.entry_passbit !== e.entry_passbit) begin
            $error("entry_passbit exp %0d got %0d", e.entry_passbit, out_if.entry_passbit);
            errors++;
          end
          if (out_if.entry_count !== e.entry_count) begin
            $error("entry_count exp %0d got %0d", e.entry_count, out_if.entry_count); errors++;
          end
          if (out_if.probe_total !== e.probe_total) begin
            $error("probe_total exp %0d got %0d", e.probe_total, out_if.probe_total); errors++;
          end
          if (out_if.passbit_count !== e.passbit_count) begin
            $error("passbit_count exp %0d got %0d", e.passbit_count, out_if.passbit_count);
            errors++;
          end
        end
      end
      if (long_hold && hold_cycles < 3000) begin
        hold_cycles <= hold_cycles + 1;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        out_if.ready <= 1'b0;
      end else if (!out_if.ready) begin
        out_if.ready <= ($urandom_range(0, 3) == 0);
      end else begin
        out_if.ready <= ($urandom_range(0, 5) != 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel
        || !rst_n || answers.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      $display("brent_double_hash_table_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.action = ACT_INSERT;
    in_if.key = '0;
    in_if.slot_index = '0;
    long_hold = 1'b0;
    errors = 0;
    size_reg = 32'(SIZE_RESET);
    brent_reg = 1;
    wipe_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_sizes();
    test_backpressure();
    test_random(500, 11, 1);
    test_random(400, 29, 0);
    test_random(400, 3, 1);
    test_random(350, 61, 1);
    test_random(150, 1024, 1);
    wait_drain();
    $display("covered %0d words: %0d inserts stored, %0d duplicates, %0d full, %0d fetch hits",
             sent, n_ins_ok, n_dup, n_full, n_found);
    $display("brent relocations %0d, sizes 0 to 2047, both insert modes", n_moves);
    if (errors == 0 && got == sent) begin
      $display("brent_double_hash_table_unit_tb: PASS");
    end else begin
      $display("brent_double_hash_table_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
